// ===== rtl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg - stack machine executor package
// Opcodes, status codes and field widths shared by the executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  localparam int unsigned OP_W     = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned NADDR_W  = 10;
  localparam int unsigned DEPTH_W  = 9;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef logic [OP_W-1:0]     opcode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_NOP   = 4'd0;
  localparam opcode_t OP_PUSH  = 4'd1;
  localparam opcode_t OP_POP   = 4'd2;
  localparam opcode_t OP_LOAD  = 4'd3;
  localparam opcode_t OP_STORE = 4'd4;
  localparam opcode_t OP_JMP   = 4'd5;
  localparam opcode_t OP_JZ    = 4'd6;
  localparam opcode_t OP_JNZ   = 4'd7;
  localparam opcode_t OP_ADD   = 4'd8;
  localparam opcode_t OP_SUB   = 4'd9;
  localparam opcode_t OP_MUL   = 4'd10;
  localparam opcode_t OP_DIV   = 4'd11;
  localparam opcode_t OP_PRINT = 4'd12;
  localparam opcode_t OP_STOP  = 4'd13;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_STOP    = 3'd1;
  localparam status_t ST_OVER    = 3'd2;
  localparam status_t ST_UNDER   = 3'd3;
  localparam status_t ST_BADOP   = 3'd4;
  localparam status_t ST_DIVZ    = 3'd5;
  localparam status_t ST_BADINST = 3'd6;

  // instruction lengths in bytes
  localparam int unsigned LEN_PUSH = 5;
  localparam int unsigned LEN_REG  = 2;
  localparam int unsigned LEN_JMP  = 3;
  localparam int unsigned LEN_ONE  = 1;

  localparam int unsigned DIV_STEPS = 32;

endpackage

// ===== rtl/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one decoded stack-machine instruction per input word.
// ----------------------------------------------------------------------------
// Channel | Dir | Ports                | Contents
// in      | in  | in_tvalid/tready     | tdata: operation[3:0], operand[35:4]
// out     | out | out_tvalid/tready    | tdata: status, print_value, next_address,
//         |     |                      |        stack_depth; tuser: print_valid
//
// A word is taken in IDLE, decoded and executed in EXEC (stack top and
// second read from the stack RAM registered on accept), then committed in FIN.
// DIV runs the restoring divider for 32 steps in state DIV before FIN; the
// rest go from EXEC to FIN. in_tready is low from accept until the commit.
// Reset (rst_n low, synchronous) empties the stack, zeroes the address, clears
// the halted flag and marks every register file entry as reading zero.
// A stalled out_tready holds the finished result in FIN until the output
// register frees up; the output register itself parts the two sides.
// ----------------------------------------------------------------------------
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH    = 256,
  parameter int unsigned REGISTER_COUNT = 16,
  parameter int unsigned PROGRAM_SIZE   = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [3:0] operation, [35:4] operand, [39:36] zero
  input  logic [sme_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [34:3] print_value, [44:35] next_address,
  // [53:45] stack_depth, [55:54] zero
  output logic [sme_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] print_valid
  output logic                              out_tuser
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(PROGRAM_SIZE);
  localparam int unsigned RW  = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned DW  = sme_pkg::DATA_W;
  localparam int unsigned DPW = sme_pkg::DEPTH_W;
  localparam int unsigned NAW = sme_pkg::NADDR_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_t;

  state_t state_r;

  // architectural state
  logic [DW-1:0]  stk_mem [STACK_DEPTH];
  logic [DW-1:0]  rf_r [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  addr_r;
  logic           halted_r;

  // captured word and stack reads
  sme_pkg::opcode_t op_r;
  logic [DW-1:0]  v_r;
  logic [DW-1:0]  rd_top_r, rd_sec_r;

  // pending commit
  sme_pkg::status_t p_status_r;
  logic           p_pvalid_r;
  logic [DW-1:0]  p_pv_r;
  logic [AW-1:0]  p_addr_r;
  logic [CW-1:0]  p_cnt_r;
  logic           p_mwe_r;
  logic [SAW-1:0] p_maddr_r;
  logic [DW-1:0]  p_mdata_r;
  logic           p_rwe_r;

  // divider
  logic [DW:0]    div_rem_r;
  logic [DW-1:0]  div_q_r;
  logic [DW-1:0]  div_mb_r;
  logic           div_neg_r;
  logic [4:0]     div_cnt_r;

  // output register
  logic                            out_valid_r;
  logic [sme_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                            out_tuser_r;

  logic [SAW-1:0] ptop, psec;
  assign ptop = count_r[SAW-1:0] - SAW'(1);
  assign psec = count_r[SAW-1:0] - SAW'(2);

  logic accept;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // address advance modulo PROGRAM_SIZE
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] a, input logic [2:0] len);
    logic [AW:0] s;
    s = {1'b0, a} + (AW+1)'(len);
    if (s >= (AW+1)'(PROGRAM_SIZE)) s = s - (AW+1)'(PROGRAM_SIZE);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] adv1, adv2, adv3, adv5;
  assign adv1 = adv(addr_r, 3'(sme_pkg::LEN_ONE));
  assign adv2 = adv(addr_r, 3'(sme_pkg::LEN_REG));
  assign adv3 = adv(addr_r, 3'(sme_pkg::LEN_JMP));
  assign adv5 = adv(addr_r, 3'(sme_pkg::LEN_PUSH));

  logic [RW-1:0] ridx;
  assign ridx = v_r[RW-1:0];

  // execute decode
  sme_pkg::status_t e_status;
  logic           e_pvalid, e_mwe, e_rwe, e_div;
  logic [DW-1:0]  e_pv, e_mdata, rf_rd;
  logic [AW-1:0]  e_next;
  logic [CW-1:0]  e_cnt;
  logic [SAW-1:0] e_maddr;
  logic           empty, lt2, full, bad_reg, bad_jmp;

  assign empty   = (count_r == '0);
  assign lt2     = (count_r < CW'(2));
  assign full    = (count_r == CW'(STACK_DEPTH));
  assign bad_reg = (v_r >= DW'(REGISTER_COUNT));
  assign bad_jmp = (v_r >= DW'(PROGRAM_SIZE));
  assign rf_rd   = rf_vld_r[ridx] ? rf_r[ridx] : '0;

  always_comb begin
    e_status = sme_pkg::ST_OK;
    e_pvalid = 1'b0;
    e_pv     = '0;
    e_next   = addr_r;
    e_cnt    = count_r;
    e_mwe    = 1'b0;
    e_maddr  = count_r[SAW-1:0];
    e_mdata  = v_r;
    e_rwe    = 1'b0;
    e_div    = 1'b0;
    if (halted_r) begin
      e_status = sme_pkg::ST_STOP;
    end else begin
      case (op_r)
        sme_pkg::OP_NOP: begin
          e_next = adv1;
        end
        sme_pkg::OP_PUSH: begin
          if (full) e_status = sme_pkg::ST_OVER;
          else begin
            e_mwe = 1'b1; e_cnt = count_r + CW'(1); e_next = adv5;
          end
        end
        sme_pkg::OP_LOAD: begin
          if (full) e_status = sme_pkg::ST_OVER;
          else if (bad_reg) e_status = sme_pkg::ST_BADOP;
          else begin
            e_mwe = 1'b1; e_mdata = rf_rd; e_cnt = count_r + CW'(1); e_next = adv2;
          end
        end
        sme_pkg::OP_POP: begin
          if (empty) e_status = sme_pkg::ST_UNDER;
          else begin
            e_cnt = count_r - CW'(1); e_next = adv1;
          end
        end
        sme_pkg::OP_STORE: begin
          if (empty) e_status = sme_pkg::ST_UNDER;
          else if (bad_reg) e_status = sme_pkg::ST_BADOP;
          else begin
            e_rwe = 1'b1; e_cnt = count_r - CW'(1); e_next = adv2;
          end
        end
        sme_pkg::OP_JMP: begin
          if (bad_jmp) e_status = sme_pkg::ST_BADOP;
          else e_next = v_r[AW-1:0];
        end
        sme_pkg::OP_JZ, sme_pkg::OP_JNZ: begin
          if (empty) e_status = sme_pkg::ST_UNDER;
          else if (bad_jmp) e_status = sme_pkg::ST_BADOP;
          else begin
            e_cnt = count_r - CW'(1);
            if ((op_r == sme_pkg::OP_JZ) == (rd_top_r == '0)) e_next = v_r[AW-1:0];
            else e_next = adv3;
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
          if (lt2) e_status = sme_pkg::ST_UNDER;
          else if (op_r == sme_pkg::OP_DIV && rd_top_r == '0) e_status = sme_pkg::ST_DIVZ;
          else begin
            e_mwe   = 1'b1;
            e_maddr = psec;
            e_cnt   = count_r - CW'(1);
            e_next  = adv1;
            case (op_r)
              sme_pkg::OP_ADD: e_mdata = rd_sec_r + rd_top_r;
              sme_pkg::OP_SUB: e_mdata = rd_sec_r - rd_top_r;
              sme_pkg::OP_MUL: e_mdata = rd_sec_r * rd_top_r;
              default:         e_div   = 1'b1;
            endcase
          end
        end
        sme_pkg::OP_PRINT: begin
          if (empty) e_status = sme_pkg::ST_UNDER;
          else begin
            e_pvalid = 1'b1; e_pv = rd_top_r; e_cnt = count_r - CW'(1); e_next = adv1;
          end
        end
        sme_pkg::OP_STOP: begin
          e_status = sme_pkg::ST_STOP;
        end
        default: begin
          e_status = sme_pkg::ST_BADINST;
        end
      endcase
      if (e_status != sme_pkg::ST_OK) begin
        e_next = addr_r; e_cnt = count_r; e_mwe = 1'b0; e_rwe = 1'b0; e_div = 1'b0;
      end
    end
  end

  // one restoring divide step
  logic [DW:0]   d_sh;
  logic          d_ge;
  logic [DW:0]   d_rem;
  logic [DW-1:0] d_q;
  assign d_sh  = {div_rem_r[DW-1:0], div_q_r[DW-1]};
  assign d_ge  = (d_sh >= {1'b0, div_mb_r});
  assign d_rem = d_ge ? (d_sh - {1'b0, div_mb_r}) : d_sh;
  assign d_q   = {div_q_r[DW-2:0], d_ge};

  logic fin_go;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // result fields at their port widths
  logic [DPW-1:0] cnt_o;
  logic [NAW-1:0] addr_o;
  assign cnt_o  = DPW'(p_cnt_r);
  assign addr_o = NAW'(p_addr_r);

  // stack RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    rd_top_r <= stk_mem[ptop];
    rd_sec_r <= stk_mem[psec];
    if (fin_go && p_mwe_r) stk_mem[p_maddr_r] <= p_mdata_r;
  end

  // register file payload
  always_ff @(posedge clk) begin
    if (fin_go && p_rwe_r) rf_r[ridx] <= rd_top_r;
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      addr_r      <= '0;
      halted_r    <= 1'b0;
      rf_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_tdata[3:0];
            v_r     <= in_tdata[35:4];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          p_status_r <= e_status;
          p_pvalid_r <= e_pvalid;
          p_pv_r     <= e_pv;
          p_addr_r   <= e_next;
          p_cnt_r    <= e_cnt;
          p_mwe_r    <= e_mwe;
          p_maddr_r  <= e_maddr;
          p_mdata_r  <= e_mdata;
          p_rwe_r    <= e_rwe;
          div_rem_r  <= '0;
          div_q_r    <= rd_sec_r[DW-1] ? (DW'(0) - rd_sec_r) : rd_sec_r;
          div_mb_r   <= rd_top_r[DW-1] ? (DW'(0) - rd_top_r) : rd_top_r;
          div_neg_r  <= rd_sec_r[DW-1] ^ rd_top_r[DW-1];
          div_cnt_r  <= '0;
          state_r    <= e_div ? S_DIV : S_FIN;
        end
        S_DIV: begin
          div_rem_r <= d_rem;
          div_q_r   <= d_q;
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'(sme_pkg::DIV_STEPS - 1)) begin
            p_mdata_r <= div_neg_r ? (DW'(0) - d_q) : d_q;
            state_r   <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            count_r  <= p_cnt_r;
            addr_r   <= p_addr_r;
            halted_r <= halted_r | (p_status_r != sme_pkg::ST_OK);
            if (p_rwe_r) rf_vld_r[ridx] <= 1'b1;
            out_valid_r <= 1'b1;
            out_tuser_r <= p_pvalid_r;
            out_tdata_r <= {2'b00, cnt_o, addr_o, p_pv_r, p_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
